// ===== rtl/sate_pkg.sv =====
// shared types and constants for the sorted array table engine
// no dependencies; imported by sate_cell, sate_ctrl and the top level
package sate_pkg;

  localparam int DEPTH_DEFAULT = 16;
  localparam int VALUE_W       = 32;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_SORTED = 2'd1,
    CMD_SEARCH = 2'd2,
    CMD_DELETE = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_DONE  = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_RANGE = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_APPLY
  } state_t;

  // broadcast control from the sequencer to every cell
  typedef struct packed {
    logic apply;    // commit the shift or load this cycle
    logic grow;     // 1 insert (shift up), 0 delete (shift down)
    logic mark;     // compute the per-cell flag against the value bus
    logic mark_eq;  // 1 flag on equal, 0 flag on entry greater than value
    logic shift;    // move flags one cell toward cell 0
  } cell_ctrl_t;

endpackage

// ===== rtl/sate_cell.sv =====
// one table cell: holds an entry and a scan flag, trades data with its neighbors
// depends on sate_pkg
module sate_cell #(
  parameter int IDX = 0,
  parameter int CW  = 5
) (
  input  logic                          clk,
  input  logic                          rst,
  input  sate_pkg::cell_ctrl_t          ctrl,
  input  logic [CW-1:0]                 target,
  input  logic [CW-1:0]                 fill,
  input  logic [sate_pkg::VALUE_W-1:0]  value,
  input  logic [sate_pkg::VALUE_W-1:0]  up_in,
  input  logic [sate_pkg::VALUE_W-1:0]  down_in,
  input  logic                          flag_in,
  output logic [sate_pkg::VALUE_W-1:0]  entry,
  output logic                          flag
);
  import sate_pkg::*;

  localparam logic [CW-1:0] IDX_C = CW'(IDX);

  logic in_use;
  logic hit;

  assign in_use = IDX_C < fill;
  assign hit    = ctrl.mark_eq ? (entry == value)
                               : ($signed(entry) > $signed(value));

  // entries carry no reset, only cells below the fill count are ever read
  always_ff @(posedge clk) begin
    if (ctrl.apply) begin
      if (ctrl.grow) begin
        if (IDX_C == target) begin
          entry <= value;
        end else if (IDX_C > target) begin
          entry <= up_in;
        end
      end else if (IDX_C >= target) begin
        entry <= down_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flag <= 1'b0;
    end else if (ctrl.mark) begin
      flag <= in_use & hit;
    end else if (ctrl.shift) begin
      flag <= flag_in;
    end
  end

endmodule

// ===== rtl/sate_ctrl.sv =====
// command sequencer: input handshake, flag scan, fill count and result register
// depends on sate_pkg; drives the shared control of the sate_cell chain
module sate_ctrl #(
  parameter int DEPTH = sate_pkg::DEPTH_DEFAULT,
  parameter int IW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    command,
  input  logic [CW-1:0]                 position,
  input  logic [sate_pkg::VALUE_W-1:0]  value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic                          found,
  output logic [IW-1:0]                 index,
  output logic [CW-1:0]                 count,
  input  logic                          flag0,
  output sate_pkg::cell_ctrl_t          ctrl,
  output logic [CW-1:0]                 target,
  output logic [CW-1:0]                 fill,
  output logic [sate_pkg::VALUE_W-1:0]  value_bus
);
  import sate_pkg::*;

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  state_t                state, state_next;
  cmd_t                  cmd_q, cmd_next;
  logic [VALUE_W-1:0]    val_q;
  logic [CW-1:0]         target_next;
  logic [CW-1:0]         fill_next;
  logic [CW-1:0]         k, k_next;
  status_t               stat_q, stat_next;
  logic                  hit_q, hit_next;
  logic                  upd, upd_next;
  logic                  out_free;
  logic                  accept;

  assign in_ready  = (state == ST_IDLE);
  assign accept    = in_valid & in_ready;
  assign out_free  = !out_valid || out_ready;
  assign value_bus = (state == ST_IDLE) ? value : val_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    cmd_q  <= cmd_next;
    target <= target_next;
    k      <= k_next;
    stat_q <= stat_next;
    hit_q  <= hit_next;
    upd    <= upd_next;
    if (accept) begin
      val_q <= value;
    end
  end

  always_comb begin
    state_next  = state;
    cmd_next    = cmd_q;
    target_next = target;
    fill_next   = fill;
    k_next      = k;
    stat_next   = stat_q;
    hit_next    = hit_q;
    upd_next    = upd;
    ctrl        = '0;
    ctrl.grow   = (cmd_q == CMD_INSERT) || (cmd_q == CMD_SORTED);
    unique case (state)
      ST_IDLE: begin
        ctrl.mark    = accept;
        ctrl.mark_eq = (cmd_t'(command) == CMD_SEARCH);
        if (accept) begin
          cmd_next    = cmd_t'(command);
          target_next = position;
          k_next      = '0;
          stat_next   = STAT_DONE;
          hit_next    = 1'b0;
          upd_next    = 1'b0;
          state_next  = ST_APPLY;
          unique case (cmd_t'(command))
            CMD_INSERT: begin
              if (fill == DEPTH_C) begin
                stat_next = STAT_FULL;
              end else if (position > fill) begin
                stat_next = STAT_RANGE;
              end else begin
                upd_next = 1'b1;
              end
            end
            CMD_SORTED: begin
              if (fill == DEPTH_C) begin
                stat_next = STAT_FULL;
              end else begin
                state_next = ST_SCAN;
              end
            end
            CMD_SEARCH: begin
              state_next = ST_SCAN;
            end
            CMD_DELETE: begin
              if (position >= fill) begin
                stat_next = STAT_RANGE;
              end else begin
                upd_next = 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // flags drift toward cell 0, so cell 0 shows the flag of index k
        if (k == fill || flag0) begin
          target_next = k;
          hit_next    = flag0 && (k != fill) && (cmd_q == CMD_SEARCH);
          upd_next    = (cmd_q == CMD_SORTED);
          state_next  = ST_APPLY;
        end else begin
          ctrl.shift = 1'b1;
          k_next     = k + CW'(1);
        end
      end
      ST_APPLY: begin
        if (out_free) begin
          ctrl.apply = upd;
          if (upd) begin
            fill_next = ctrl.grow ? fill + CW'(1) : fill - CW'(1);
          end
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_APPLY && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_APPLY && out_free) begin
      status <= stat_q;
      found  <= hit_q;
      count  <= fill_next;
      if (stat_q == STAT_DONE &&
          (cmd_q == CMD_INSERT || cmd_q == CMD_SORTED || hit_q)) begin
        index <= target[IW-1:0];
      end else begin
        index <= '0;
      end
    end
  end

endmodule

// ===== rtl/sorted_array_table_engine.sv =====
// sorted array table engine: a row of DEPTH cells under one sequencer.
// insert at position, delete and any rejected command go from accept to the apply state,
// which registers the result. search and sorted insert scan the flags one cell per cycle
// until a hit or the fill count, then go to the apply state.
// one item at a time, taken the cycle after the result registers; an out_ready stall holds
// the apply state, and reset clears fill count and handshake.
module sorted_array_table_engine #(
  parameter int DEPTH = sate_pkg::DEPTH_DEFAULT,
  parameter int IW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    command,
  input  logic [CW-1:0]                 position,
  input  logic [sate_pkg::VALUE_W-1:0]  value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    status,
  output logic                          found,
  output logic [IW-1:0]                 index,
  output logic [CW-1:0]                 count
);
  import sate_pkg::*;

  cell_ctrl_t          ctrl;
  logic [CW-1:0]       target;
  logic [CW-1:0]       fill;
  logic [VALUE_W-1:0]  value_bus;
  logic [VALUE_W-1:0]  entry [DEPTH];
  logic                flag  [DEPTH];

  sate_ctrl #(
    .DEPTH (DEPTH),
    .IW    (IW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .command   (command),
    .position  (position),
    .value     (value),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .found     (found),
    .index     (index),
    .count     (count),
    .flag0     (flag[0]),
    .ctrl      (ctrl),
    .target    (target),
    .fill      (fill),
    .value_bus (value_bus)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [VALUE_W-1:0] up_in;
    logic [VALUE_W-1:0] down_in;
    logic               flag_in;

    // ends of the row: cell 0 never shifts up, the last cell never shifts down
    if (i == 0) begin : g_first
      assign up_in = value_bus;
    end else begin : g_up
      assign up_in = entry[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign down_in = entry[i];
      assign flag_in = 1'b0;
    end else begin : g_down
      assign down_in = entry[i+1];
      assign flag_in = flag[i+1];
    end

    sate_cell #(
      .IDX (i),
      .CW  (CW)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .target  (target),
      .fill    (fill),
      .value   (value_bus),
      .up_in   (up_in),
      .down_in (down_in),
      .flag_in (flag_in),
      .entry   (entry[i]),
      .flag    (flag[i])
    );
  end

endmodule
